// ===== rtl/osc_pkg.sv =====
// ----------------------------------------------------------------------------
// Oscillator mixer package
// Shared constants, note tables, codes and the sine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package osc_pkg;

    localparam int NOTE_COUNT      = 12;
    localparam int NOTE_IDX_W      = 4;
    localparam int VOICES_DEF      = 12;
    localparam int SINE_LENGTH_DEF = 100;

    localparam int MIX_W = 16;
    localparam int DVD_W = 15;
    localparam int DVS_W = 7;

    localparam logic [33:0] PERIOD_NUM  = 34'd9011200000;
    localparam logic [63:0] TURN_CENTI  = 64'd2200000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [31:0] NOTE_STEP [NOTE_COUNT] = '{
        32'd51076056, 32'd54113197, 32'd57330935, 32'd60740010,
        32'd64351799, 32'd68178356, 32'd72232452, 32'd76527617,
        32'd81078186, 32'd85899345, 32'd91007186, 32'd96418755
    };

    localparam logic [15:0] NOTE_CENTIHZ [NOTE_COUNT] = '{
        16'd26163, 16'd27718, 16'd29366, 16'd31113, 16'd32963, 16'd34923,
        16'd36999, 16'd39200, 16'd41530, 16'd44000, 16'd46616, 16'd49388
    };

    localparam logic [1:0] WAVE_SAW    = 2'd0;
    localparam logic [1:0] WAVE_SINE   = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;

    localparam logic REG_WAVEFORM = 1'b0;
    localparam logic REG_VOLUME   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_EVAL,
        ST_ACC,
        ST_CLEAR,
        ST_DIV,
        ST_OUT
    } state_t;

    // Sine sample of a note at a table position, evaluated at elaboration.
    function automatic logic [8:0] sine_entry(input logic [63:0] fc, input logic [63:0] idx);
        logic [63:0] num;
        logic [63:0] p64;
        logic [31:0] p;
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] s;
        logic [63:0] mag;
        logic [8:0]  v;
        num  = (fc * idx) % TURN_CENTI;
        p64  = (num << 32) / TURN_CENTI;
        p    = p64[31:0];
        quad = p[31:30];
        r    = {34'd0, p[29:0]};
        if (quad[0]) begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        s    = $signed(x);
        term = x;
        for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                s = s - $signed(term);
            end else begin
                s = s + $signed(term);
            end
        end
        mag = (s < 0) ? 64'd0 : $unsigned(s);
        v   = mag[31:23];
        return quad[1] ? 9'(-v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/polyphonic_oscillator_mixer_core.sv =====
// Each note slot (up to twelve notes) steps through the read, multiply, evaluate and
// accumulate states; a clear state follows, then the divider in sine mode with two or
// more notes, then the output state. A new sample is accepted only in the idle state,
// so the per-note read, multiply and write-back on the state memories never overlap.
// Reset (aresetn, synchronous, active low) clears all oscillator state through
// valid bits, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// Polyphonic oscillator mixer core
// Mixes sawtooth, sine or square voices for the pressed notes into one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphonic_oscillator_mixer_core #(
    parameter int VOICES      = osc_pkg::VOICES_DEF,
    parameter int SINE_LENGTH = osc_pkg::SINE_LENGTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [11:0] s_key_mask,
    input  wire logic [15:0] s_pitch_factor,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_sample
);

    import osc_pkg::*;

    localparam int ACTIVE = (VOICES < NOTE_COUNT) ? VOICES : NOTE_COUNT;
    localparam int SW     = $clog2(ACTIVE + 1);
    localparam int VW     = $clog2(VOICES + 1);
    localparam int AAW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CAW    = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam int IW     = $clog2(SINE_LENGTH);

    state_t                  state_reg, state_next;
    logic [1:0]              wave_reg;
    logic [4:0]              vol_reg;
    logic [11:0]             mask_reg, mask_next;
    logic [15:0]             pitch_reg, pitch_next;
    logic [NOTE_IDX_W-1:0]   note_reg, note_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic signed [MIX_W-1:0] mix_reg, mix_next;
    logic [31:0]             fcp_reg, fcp_next;
    logic [31:0]             inc_reg, inc_next;
    logic [39:0]             prod_reg, prod_next;
    logic [31:0]             acc_cur_reg, acc_cur_next;
    logic [15:0]             ctrs_reg, ctrs_next;
    logic                    acc_rv_reg, acc_rv_next;
    logic                    ctr_rv_reg, ctr_rv_next;
    logic                    neg_reg, neg_next;
    logic                    acc_vld_reg [VOICES];
    logic                    ctr_vld_reg [ACTIVE];
    logic                    m_valid_reg, m_valid_next;
    logic [7:0]              m_sample_reg, m_sample_next;

    logic                    acc_vld_sel;
    logic                    ctr_vld_sel;
    logic                    pressed;
    logic                    acc_we;
    logic [31:0]             acc_wdata;
    logic [31:0]             acc_rdata;
    logic                    ctr_we;
    logic [15:0]             ctr_wdata;
    logic [15:0]             ctr_rdata;
    logic [8:0]              rom_data;
    logic [7:0]              cnt_sel;
    logic [7:0]              cnt_wrap;
    logic                    wrap;
    logic [7:0]              cnt_new;
    logic [IW-1:0]           rom_idx;
    logic [31:0]             acc_new;
    logic [47:0]             step_prod;
    logic                    div_start;
    logic                    div_done;
    logic [DVD_W-1:0]        div_dvd;
    logic [DVS_W-1:0]        div_dvs;
    logic [DVD_W-1:0]        div_quo;
    logic signed [MIX_W-1:0] mix10;
    logic [3:0]              half_vol;
    logic [3:0]              shamt;
    logic signed [MIX_W-1:0] shifted;
    logic [7:0]              sat;

    always_comb begin
        acc_vld_sel = 1'b0;
        for (int s = 0; s < VOICES; s++) begin
            if (VW'(s) == VW'(slot_reg)) begin
                acc_vld_sel = acc_vld_reg[s];
            end
        end
        ctr_vld_sel = 1'b0;
        for (int n = 0; n < ACTIVE; n++) begin
            if (NOTE_IDX_W'(n) == note_reg) begin
                ctr_vld_sel = ctr_vld_reg[n];
            end
        end
    end

    assign pressed   = mask_reg[note_reg];
    assign step_prod = NOTE_STEP[note_reg] * pitch_reg;
    assign cnt_sel   = (wave_reg == WAVE_SINE) ? ctrs_reg[15:8] : ctrs_reg[7:0];
    assign wrap      = (wave_reg == WAVE_SINE)
                     ? (({1'b0, cnt_sel} >= 9'(SINE_LENGTH)) || (prod_reg >= 40'(PERIOD_NUM)))
                     : (prod_reg > 40'(PERIOD_NUM));
    assign cnt_wrap  = wrap ? 8'd0 : cnt_sel;
    assign cnt_new   = pressed ? cnt_wrap + 8'd1 : cnt_wrap;
    assign rom_idx   = cnt_wrap[IW-1:0];
    assign acc_new   = acc_cur_reg + inc_reg;
    assign mix10     = (mix_reg <<< 3) + (mix_reg <<< 1);
    assign div_dvd   = mix10[MIX_W-1] ? DVD_W'(-mix10) : DVD_W'(mix10);
    assign div_dvs   = DVS_W'({slot_reg, 3'b000}) + DVS_W'(slot_reg);
    assign half_vol  = vol_reg[4:1];
    assign shamt     = (half_vol >= 4'd8) ? 4'd0 : 4'd8 - half_vol;
    assign shifted   = mix_reg >>> shamt;
    assign sat       = (shifted > 16'sd127) ? 8'd127
                     : (shifted < -16'sd128) ? 8'h80 : shifted[7:0];

    always_comb begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        pitch_next    = pitch_reg;
        note_next     = note_reg;
        slot_next     = slot_reg;
        mix_next      = mix_reg;
        fcp_next      = fcp_reg;
        inc_next      = inc_reg;
        prod_next     = prod_reg;
        acc_cur_next  = acc_cur_reg;
        ctrs_next     = ctrs_reg;
        acc_rv_next   = acc_rv_reg;
        ctr_rv_next   = ctr_rv_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg;
        m_sample_next = m_sample_reg;
        acc_we        = 1'b0;
        acc_wdata     = acc_new;
        ctr_we        = 1'b0;
        ctr_wdata     = ctrs_reg;
        div_start     = 1'b0;
        s_ready       = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid) begin
                    mask_next  = s_key_mask;
                    pitch_next = s_pitch_factor;
                    note_next  = '0;
                    slot_next  = '0;
                    mix_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                fcp_next    = NOTE_CENTIHZ[note_reg] * pitch_reg;
                inc_next    = step_prod[43:12];
                acc_rv_next = acc_vld_sel;
                ctr_rv_next = ctr_vld_sel;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                acc_cur_next = acc_rv_reg ? acc_rdata : 32'd0;
                ctrs_next    = ctr_rv_reg ? ctr_rdata : 16'd0;
                prod_next    = (ctr_rv_reg ? ((wave_reg == WAVE_SINE) ? ctr_rdata[15:8]
                                                                      : ctr_rdata[7:0])
                                           : 8'd0) * fcp_reg;
                state_next   = ST_EVAL;
            end
            ST_EVAL: begin
                case (wave_reg)
                    WAVE_SAW: begin
                        if (pressed) begin
                            acc_we   = 1'b1;
                            mix_next = mix_reg + {{(MIX_W - 7){acc_new[31]}}, acc_new[31:25]};
                        end
                    end
                    WAVE_SINE: begin
                        ctr_we    = 1'b1;
                        ctr_wdata = {cnt_new, ctrs_reg[7:0]};
                    end
                    WAVE_SQUARE: begin
                        ctr_we    = 1'b1;
                        ctr_wdata = {ctrs_reg[15:8], cnt_new};
                        if (pressed) begin
                            if ((cnt_wrap != 8'd0) && ({prod_reg, 1'b0} > 41'(PERIOD_NUM))) begin
                                mix_next = mix_reg + 16'sd128;
                            end else begin
                                mix_next = mix_reg - 16'sd128;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (pressed) begin
                    slot_next = slot_reg + 1'b1;
                end
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if ((wave_reg == WAVE_SINE) && pressed) begin
                    mix_next = mix_reg + {{(MIX_W - 9){rom_data[8]}}, rom_data};
                end
                if (note_reg == NOTE_IDX_W'(ACTIVE - 1)) begin
                    state_next = ST_CLEAR;
                end else begin
                    note_next  = note_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_CLEAR: begin
                if ((wave_reg == WAVE_SINE) && (slot_reg >= SW'(2))) begin
                    div_start  = 1'b1;
                    neg_next   = mix10[MIX_W-1];
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mix_next   = neg_reg ? -$signed(MIX_W'(div_quo)) : $signed(MIX_W'(div_quo));
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = {~sat[7], sat[6:0]};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            wave_reg    <= WAVE_SAW;
            vol_reg     <= 5'd13;
            for (int s = 0; s < VOICES; s++) begin
                acc_vld_reg[s] <= 1'b0;
            end
            for (int n = 0; n < ACTIVE; n++) begin
                ctr_vld_reg[n] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_WAVEFORM: wave_reg <= cfg_wdata[1:0];
                    REG_VOLUME:   vol_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            for (int s = 0; s < VOICES; s++) begin
                if (acc_we && (VW'(s) == VW'(slot_reg))) begin
                    acc_vld_reg[s] <= 1'b1;
                end else if ((state_reg == ST_CLEAR) && (VW'(s) >= VW'(slot_reg))) begin
                    acc_vld_reg[s] <= 1'b0;
                end
            end
            for (int n = 0; n < ACTIVE; n++) begin
                if (ctr_we && (NOTE_IDX_W'(n) == note_reg)) begin
                    ctr_vld_reg[n] <= 1'b1;
                end
            end
        end
        mask_reg     <= mask_next;
        pitch_reg    <= pitch_next;
        note_reg     <= note_next;
        slot_reg     <= slot_next;
        mix_reg      <= mix_next;
        fcp_reg      <= fcp_next;
        inc_reg      <= inc_next;
        prod_reg     <= prod_next;
        acc_cur_reg  <= acc_cur_next;
        ctrs_reg     <= ctrs_next;
        acc_rv_reg   <= acc_rv_next;
        ctr_rv_reg   <= ctr_rv_next;
        neg_reg      <= neg_next;
        m_sample_reg <= m_sample_next;
    end

    osc_ram #(
        .WIDTH (32),
        .DEPTH (VOICES)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (AAW'(slot_reg)),
        .wdata (acc_wdata),
        .raddr (AAW'(slot_reg)),
        .rdata (acc_rdata)
    );

    osc_ram #(
        .WIDTH (16),
        .DEPTH (ACTIVE)
    ) u_ctr_ram (
        .aclk  (aclk),
        .we    (ctr_we),
        .waddr (CAW'(note_reg)),
        .wdata (ctr_wdata),
        .raddr (CAW'(note_reg)),
        .rdata (ctr_rdata)
    );

    osc_sine_rom #(
        .SINE_LENGTH (SINE_LENGTH)
    ) u_sine_rom (
        .aclk (aclk),
        .note (note_reg),
        .idx  (rom_idx),
        .data (rom_data)
    );

    osc_div #(
        .N (DVD_W),
        .D (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

`ifndef ASSERT_OFF
    a_slot_le_note: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (VW'(slot_reg) <= VW'(note_reg)))
        else $error("slot count ran ahead of the note walk");

    a_div_sine_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (wave_reg == WAVE_SINE))
        else $error("divider active outside sine mode");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_READ && note_reg == '0))
        else $error("accepted transfer did not start the note walk");
`endif

endmodule

`default_nettype wire

// ===== rtl/osc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/osc_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Sine table ROM
// One period segment of sine samples per note, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_sine_rom #(
    parameter int SINE_LENGTH = osc_pkg::SINE_LENGTH_DEF,
    parameter int IW          = $clog2(SINE_LENGTH)
) (
    input  wire logic                          aclk,
    input  wire logic [osc_pkg::NOTE_IDX_W-1:0] note,
    input  wire logic [IW-1:0]                 idx,
    output logic      [8:0]                    data
);

    import osc_pkg::*;

    logic [8:0] rom_w [NOTE_COUNT][SINE_LENGTH];
    logic [8:0] data_reg;

    for (genvar gn = 0; gn < NOTE_COUNT; gn++) begin : g_note
        for (genvar gi = 0; gi < SINE_LENGTH; gi++) begin : g_idx
            localparam logic [8:0] VAL = sine_entry(64'(NOTE_CENTIHZ[gn]), 64'(gi));
            assign rom_w[gn][gi] = VAL;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= rom_w[note][idx];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/osc_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_div #(
    parameter int N = osc_pkg::DVD_W,
    parameter int D = osc_pkg::DVS_W
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              done,
    output logic      [N-1:0] quotient
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [D-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [D:0]    rem_sh;
    logic [D:0]    diff;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[N-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = diff[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
